// File: rtl/core/sorted_table_insert_and_bounds_core_macros.svh
// ----------------------------------------------------------------------------
// sorted table core assertion macros
// shared concurrent assertion forms for the sorted table core
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_AND_BOUNDS_CORE_MACROS_SVH
`define SORTED_TABLE_INSERT_AND_BOUNDS_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define STIB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define STIB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/stib_pkg.sv
// ----------------------------------------------------------------------------
// stib_pkg
// shared constants and types of the sorted table core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stib_pkg;

    localparam int DEPTH   = 256;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int MODE_W  = 2;
    localparam int POS_W   = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOWER  = 2'd1,
        MODE_UPPER  = 2'd2
    } t_mode;

    typedef logic [MODE_W-1:0]        t_mode_field;
    typedef logic signed [DATA_W-1:0] t_key;
    typedef logic [POS_W-1:0]         t_pos;

endpackage

// File: rtl/core/stib_in_if.sv
// ----------------------------------------------------------------------------
// stib_in_if
// request channel: mode and key value with valid / ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stib_in_if;
    import stib_pkg::*;

    logic        valid;
    logic        ready;
    t_mode_field mode;
    t_key        key_value;

    modport source (output valid, output mode, output key_value, input ready);
    modport sink   (input valid, input mode, input key_value, output ready);
endinterface

// File: rtl/core/stib_out_if.sv
// ----------------------------------------------------------------------------
// stib_out_if
// result channel: position, status and entry count with valid / ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stib_out_if;
    import stib_pkg::*;

    logic valid;
    logic ready;
    t_pos position;
    logic status;
    t_pos entry_count;

    modport source (output valid, output position, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input position, input status, input entry_count,
                    output ready);
endinterface

// File: rtl/core/stib_ram.sv
// ----------------------------------------------------------------------------
// stib_ram
// generic single write port / single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stib_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/core/stib_cmp.sv
// ----------------------------------------------------------------------------
// stib_cmp
// shared signed compare unit for the binary search steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stib_cmp (
    input  stib_pkg::t_key i_entry,
    input  stib_pkg::t_key i_key,
    input  logic           i_strict,
    output logic           o_go_right
);
    import stib_pkg::*;

    logic lt;
    logic eq;

    assign lt = (i_entry < i_key);
    assign eq = (i_entry == i_key);

    // strict: entry <= key moves right (upper bound), else entry < key
    assign o_go_right = lt | (i_strict & eq);

endmodule

// File: rtl/core/sorted_table_insert_and_bounds_core.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_and_bounds_core
// sorted table of signed values with insert, lower bound and upper bound
// ----------------------------------------------------------------------------
// usage:
//   i_item carries one request per transfer (mode, key_value); o_res returns
//   exactly one result per request (position, status, entry_count).
//   mode insert places the key after all entries <= key and reports the slot;
//   lower / upper bound report the first index not less / greater than key.
//   an insert into a full table is dropped with status 1; an unused mode
//   reports position 0 with status 0.
// sequence:
//   each halving step of the search reads the ram, then compares; an insert
//   then moves the entries at and above the slot up one at a time and
//   writes the key into the freed slot.
//   the single ram read port and shared compare unit set this pace.
// throughput: one request at a time; i_item.ready is high only when idle.
// reset: synchronous, active low; the table is emptied by clearing the count,
//   no sweep of the ram is needed.
// stall: the result sits in an output register; a new request is accepted
//   while it waits, and the next result is held back until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_table_insert_and_bounds_core_macros.svh"

module sorted_table_insert_and_bounds_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stib_in_if.sink     i_item,
    stib_out_if.source  o_res
);
    import stib_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_SHIFT,
        S_PUT,
        S_DONE
    } t_state;

    // sequencer state
    t_state              r_state,     n_state;
    t_mode_field         r_mode,      n_mode;
    t_key                r_key,       n_key;
    logic [CNT_W-1:0]    r_lo,        n_lo;       // search low end, later the slot
    logic [CNT_W-1:0]    r_len,       n_len;      // entries still in range
    logic [ADDR_W-1:0]   r_mid,       n_mid;      // index read for this step
    logic [CNT_W-1:0]    r_idx,       n_idx;      // next destination of the move
    logic                r_wr_pend,   n_wr_pend;  // a moved entry lands this cycle
    logic [ADDR_W-1:0]   r_wr_addr,   n_wr_addr;
    logic [CNT_W-1:0]    r_count,     n_count;
    logic [CNT_W-1:0]    r_pos,       n_pos;
    logic                r_status,    n_status;

    // output register
    logic                r_out_valid, n_out_valid;
    t_pos                r_out_pos,   n_out_pos;
    logic                r_out_stat,  n_out_stat;
    t_pos                r_out_cnt,   n_out_cnt;

    // ram port and compare unit
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic                go_right;

    logic [CNT_W-1:0]    half;
    logic [CNT_W-1:0]    mid_full;
    logic                accept;
    logic                out_free;

    assign half     = r_len >> 1;
    assign mid_full = r_lo + half;
    assign accept   = i_item.valid && i_item.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign i_item.ready      = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.position    = r_out_pos;
    assign o_res.status      = r_out_stat;
    assign o_res.entry_count = r_out_cnt;

    stib_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    stib_cmp u_cmp (
        .i_entry    ($signed(ram_rdata)),
        .i_key      (r_key),
        .i_strict   (r_mode != MODE_LOWER),
        .o_go_right (go_right)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_key       = r_key;
        n_lo        = r_lo;
        n_len       = r_len;
        n_mid       = r_mid;
        n_idx       = r_idx;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_count     = r_count;
        n_pos       = r_pos;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_pos   = r_out_pos;
        n_out_stat  = r_out_stat;
        n_out_cnt   = r_out_cnt;

        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = ram_rdata;
        ram_raddr = mid_full[ADDR_W-1:0];

        // result taken by the sink
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode   = i_item.mode;
                    n_key    = i_item.key_value;
                    n_lo     = '0;
                    n_len    = r_count;
                    n_pos    = '0;
                    n_status = 1'b0;
                    if (i_item.mode == MODE_INSERT) begin
                        if (r_count >= CNT_W'(DEPTH)) begin
                            // full table: drop and flag
                            n_status = 1'b1;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SRCH;
                        end
                    end else if (i_item.mode == MODE_LOWER || i_item.mode == MODE_UPPER) begin
                        n_state = S_SRCH;
                    end else begin
                        // unused mode reports the count only
                        n_state = S_DONE;
                    end
                end
            end
            S_SRCH: begin
                if (r_len == '0) begin
                    if (r_mode == MODE_INSERT) begin
                        n_idx   = r_count;
                        n_state = S_SHIFT;
                    end else begin
                        n_pos   = r_lo;
                        n_state = S_DONE;
                    end
                end else begin
                    // read address goes out now, data is compared next cycle
                    n_mid   = mid_full[ADDR_W-1:0];
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (go_right) begin
                    n_lo  = CNT_W'(r_mid) + CNT_W'(1);
                    n_len = r_len - half - CNT_W'(1);
                end else begin
                    n_len = half;
                end
                n_state = S_SRCH;
            end
            S_SHIFT: begin
                // write back the entry read last cycle, one slot higher
                ram_we    = r_wr_pend;
                ram_waddr = r_wr_addr;
                ram_wdata = ram_rdata;
                ram_raddr = r_idx[ADDR_W-1:0] - ADDR_W'(1);
                if (r_idx > r_lo) begin
                    n_wr_pend = 1'b1;
                    n_wr_addr = r_idx[ADDR_W-1:0];
                    n_idx     = r_idx - CNT_W'(1);
                end else if (!r_wr_pend) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_lo[ADDR_W-1:0];
                ram_wdata = r_key;
                n_count   = r_count + CNT_W'(1);
                n_pos     = r_lo;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = POS_W'(r_pos);
                    n_out_stat  = r_status;
                    n_out_cnt   = POS_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
        r_mode     <= n_mode;
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_len      <= n_len;
        r_mid      <= n_mid;
        r_idx      <= n_idx;
        r_wr_addr  <= n_wr_addr;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_out_pos  <= n_out_pos;
        r_out_stat <= n_out_stat;
        r_out_cnt  <= n_out_cnt;
    end

    // the table never holds more than its depth
    `STIB_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "count above depth")
    // a dropped insert is only reported with a full table
    `STIB_ASSERT_IMP(a_full_flag, i_clk, i_rst_n, o_res.valid && o_res.status, o_res.entry_count == POS_W'(DEPTH), "full flag with room left")
    // the final write of an insert grows the table by one
    `STIB_ASSERT_NXT(a_put_grows, i_clk, i_rst_n, r_state == S_PUT, r_count == $past(r_count) + CNT_W'(1), "insert did not grow count")
    // the move never runs below the insert slot
    `STIB_ASSERT_IMP(a_shift_floor, i_clk, i_rst_n, r_state == S_SHIFT, r_idx >= r_lo, "move ran below slot")

endmodule
